// ----- sv/csm_pkg.sv -----
// ----------------------------------------------------------------------------
// csm_pkg: shared types and constants for the column softmax unit
// Widths, exponential constants and the 2^(-h/16) table.
// ----------------------------------------------------------------------------
package csm_pkg;
  localparam int ROWS = 16;
  localparam int IDX_W = $clog2(ROWS);
  localparam int CNT_W = $clog2(ROWS + 1);
  localparam int SCORE_W = 16;
  localparam int PROB_W = 17;
  localparam int EXP_W = 17;
  localparam int SUM_W = EXP_W + CNT_W;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  function automatic logic [16:0] pow2_frac(input logic [3:0] h);
    logic [16:0] r;
    case (h)
      4'd0: r = 17'd65536;
      4'd1: r = 17'd62757;
      4'd2: r = 17'd60097;
      4'd3: r = 17'd57549;
      4'd4: r = 17'd55109;
      4'd5: r = 17'd52773;
      4'd6: r = 17'd50535;
      4'd7: r = 17'd48393;
      4'd8: r = 17'd46341;
      4'd9: r = 17'd44376;
      4'd10: r = 17'd42495;
      4'd11: r = 17'd40693;
      4'd12: r = 17'd38968;
      4'd13: r = 17'd37316;
      4'd14: r = 17'd35734;
      default: r = 17'd34219;
    endcase
    return r;
  endfunction
endpackage

// ----- sv/csm_if.sv -----
// ----------------------------------------------------------------------------
// csm_if: valid/ready channels for scores and probabilities
// One interface per channel direction, each with source and sink modports.
// ----------------------------------------------------------------------------
interface csm_score_if;
  logic valid;
  logic ready;
  logic signed [csm_pkg::SCORE_W-1:0] score;
  logic last_in_column;
  modport source (output valid, output score, output last_in_column, input ready);
  modport sink (input valid, input score, input last_in_column, output ready);
endinterface

interface csm_prob_if;
  logic valid;
  logic ready;
  logic [csm_pkg::PROB_W-1:0] probability;
  logic [3:0] row_index;
  logic last_of_column;
  logic overflow;
  modport source (output valid, output probability, output row_index,
                  output last_of_column, output overflow, input ready);
  modport sink (input valid, input probability, input row_index,
                input last_of_column, input overflow, output ready);
endinterface

// ----- sv/csm_divider.sv -----
// ----------------------------------------------------------------------------
// csm_divider: restoring divider, one quotient bit per cycle
// Computes round-half-up (e << 16) / sum.
// ----------------------------------------------------------------------------
module csm_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [csm_pkg::EXP_W-1:0] e,
  input  logic [csm_pkg::SUM_W-1:0] sum,
  output logic done,
  output logic [csm_pkg::PROB_W-1:0] quotient
);
  localparam int NUM_W = csm_pkg::EXP_W + 16 + 1;
  localparam int STEPS = NUM_W;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] quo;
  logic [csm_pkg::SUM_W:0] rem;
  logic [csm_pkg::SUM_W-1:0] den;
  logic [STEP_W-1:0] steps;
  logic busy;
  logic [csm_pkg::SUM_W:0] trial;

  assign trial = {rem[csm_pkg::SUM_W-1:0], num[NUM_W-1]};
  assign quotient = quo[csm_pkg::PROB_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // numerator = (e << 16) + (sum >> 1)
        num <= {1'b0, e, 16'd0} + NUM_W'(sum >> 1);
        den <= sum;
        rem <= '0;
        quo <= '0;
        steps <= STEP_W'(STEPS);
        busy <= 1'b1;
      end else if (busy) begin
        num <= {num[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- sv/column_softmax_unit.sv -----
// ----------------------------------------------------------------------------
// column_softmax_unit: max-subtracted softmax over one matrix column
// Stores a column of Q5.10 scores, then emits floored Q1.16 probabilities.
// ----------------------------------------------------------------------------
// channel     dir  payload
// in_ch       in   score (s16 Q5.10), last_in_column
// out_ch      out  probability (u17 Q1.16), row_index, last_of_column, overflow
// cfg         in   cfg_we / cfg_data: probability_floor
//
// A non-last score is accepted and the input stays ready. After the last score
// each stored row passes S_READ and S_E1 to S_E6 to form exp(score - max) on
// one shared 17x17 multiplier (pass one, building the sum), then pass two:
// S_LOAD, S_DIV (divider start), S_WAIT for the 34-step divider, S_EMIT with
// the output register. Input stays not ready until out_ch.ready takes the
// column's last result. Reset is synchronous, clears control and column
// state and sets the floor to 1; the score store is not cleared.
module column_softmax_unit (
  input  logic clk,
  input  logic rst,
  csm_score_if.sink in_ch,
  csm_prob_if.source out_ch,
  input  logic cfg_we,
  input  logic [csm_pkg::PROB_W-1:0] cfg_data
);
  typedef enum logic [3:0] {
    S_COLLECT, S_READ, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6,
    S_LOAD, S_DIV, S_WAIT, S_EMIT
  } state_t;

  state_t state;
  logic signed [csm_pkg::SCORE_W-1:0] score_store [csm_pkg::ROWS];
  logic [csm_pkg::EXP_W-1:0] e_store [csm_pkg::ROWS];
  logic [csm_pkg::CNT_W-1:0] entry_count;
  logic signed [csm_pkg::SCORE_W-1:0] running_max;
  logic overflow_seen;
  logic [csm_pkg::PROB_W-1:0] floor_reg;
  logic [csm_pkg::IDX_W-1:0] row;
  logic [csm_pkg::SUM_W-1:0] sum;
  logic signed [csm_pkg::SCORE_W-1:0] rd_score;
  logic [csm_pkg::EXP_W-1:0] e_rd;

  // exponential working registers
  logic [16:0] xdiff;
  logic [23:0] u;
  logic [11:0] a;
  logic [16:0] p;
  logic [16:0] m;

  // shared multiplier
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic div_start;
  logic div_done;
  logic [csm_pkg::PROB_W-1:0] div_q;

  csm_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .e(e_rd), .sum(sum),
    .done(div_done), .quotient(div_q)
  );

  // floor above one saturates to one
  logic [csm_pkg::PROB_W-1:0] floor_v;
  assign floor_v = (floor_reg > csm_pkg::ONE_Q16) ? csm_pkg::ONE_Q16 : floor_reg;

  logic [csm_pkg::PROB_W-1:0] prob;
  assign prob = (div_q < floor_v) ? floor_v : div_q;

  logic [csm_pkg::CNT_W-1:0] last_row;
  logic is_last_row;
  assign last_row = entry_count - 1'b1;
  assign is_last_row = ({1'b0, row} == last_row);

  assign in_ch.ready = (state == S_COLLECT);
  assign div_start = (state == S_DIV);

  // integer part k of x*log2(e); beyond 16 the exponential rounds to zero
  logic [7:0] k;
  logic [4:0] kshift;
  logic [17:0] m_rnd;
  logic [csm_pkg::EXP_W-1:0] e_calc;
  assign k = u[23:16];
  assign kshift = k[4:0];
  assign m_rnd = ({1'b0, m} + (18'd1 << (kshift - 5'd1))) >> kshift;

  always_comb begin
    if (k > 8'd16) begin
      e_calc = '0;
    end else if (k == 8'd0) begin
      e_calc = m;
    end else begin
      e_calc = m_rnd[csm_pkg::EXP_W-1:0];
    end
  end

  always_comb begin
    case (state)
      S_E2: begin
        mul_a = xdiff;
        mul_b = csm_pkg::LOG2E_Q16;
      end
      S_E3: begin
        mul_a = {5'd0, u[11:0]};
        mul_b = {1'b0, csm_pkg::LN2_Q16};
      end
      S_E4: begin
        mul_a = {5'd0, a};
        mul_b = {5'd0, a};
      end
      S_E5: begin
        mul_a = csm_pkg::pow2_frac(u[15:12]);
        mul_b = p;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // registered reads of both stores at the current row
    rd_score <= score_store[row];
    e_rd <= e_store[row];
    if (rst) begin
      state <= S_COLLECT;
      entry_count <= '0;
      running_max <= {1'b1, 15'd0};
      overflow_seen <= 1'b0;
      out_ch.valid <= 1'b0;
      floor_reg <= 17'd1;
      row <= '0;
      sum <= '0;
    end else begin
      if (cfg_we) floor_reg <= cfg_data;
      case (state)
        S_COLLECT: begin
          if (in_ch.valid) begin
            // store while there is room, else drop and flag the column
            if (entry_count < csm_pkg::CNT_W'(csm_pkg::ROWS)) begin
              score_store[entry_count[csm_pkg::IDX_W-1:0]] <= in_ch.score;
              if (in_ch.score > running_max) running_max <= in_ch.score;
              entry_count <= entry_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            // a dropped last entry still ends the column
            if (in_ch.last_in_column) begin
              row <= '0;
              sum <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // rd_score for this row lands at the end of this cycle
          state <= S_E1;
        end
        S_E1: begin
          xdiff <= {running_max[15], running_max} - {rd_score[15], rd_score};
          state <= S_E2;
        end
        S_E2: begin
          u <= 24'((mul_p + 35'd512) >> 10);
          state <= S_E3;
        end
        S_E3: begin
          a <= 12'((mul_p + 34'd32768) >> 16);
          state <= S_E4;
        end
        S_E4: begin
          p <= csm_pkg::ONE_Q16 - {5'd0, a} + 17'((mul_p + 34'd65536) >> 17);
          state <= S_E5;
        end
        S_E5: begin
          m <= 17'((mul_p + 34'd32768) >> 16);
          state <= S_E6;
        end
        S_E6: begin
          // keep the exponential for pass two and build the sum
          e_store[row] <= e_calc;
          sum <= sum + {{(csm_pkg::SUM_W - csm_pkg::EXP_W){1'b0}}, e_calc};
          if (is_last_row) begin
            row <= '0;
            state <= S_LOAD;
          end else begin
            row <= row + 1'b1;
            state <= S_READ;
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            out_ch.probability <= prob;
            out_ch.row_index <= row;
            out_ch.last_of_column <= is_last_row;
            out_ch.overflow <= overflow_seen;
            out_ch.valid <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold the transaction until taken, then advance or close the column
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (is_last_row) begin
              entry_count <= '0;
              running_max <= {1'b1, 15'd0};
              overflow_seen <= 1'b0;
              row <= '0;
              state <= S_COLLECT;
            end else begin
              row <= row + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end
endmodule

// ----- dv/csm_tb_if.sv -----
// ----------------------------------------------------------------------------
// csm_tb_if: testbench-side channel notes
// The channel interfaces come with the RTL (csm_score_if, csm_prob_if); this
// file holds the shared field record used by the probability checker.
// ----------------------------------------------------------------------------
package csm_tb_pkg;
  typedef struct packed {
    logic [16:0] probability;
    logic [3:0]  row_index;
    logic        last_of_column;
    logic        overflow;
  } prob_rec_t;
endpackage

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: column softmax unit testbench
// Streams score columns through the unit and compares every emitted
// probability with a local fixed-point softmax predictor, across several
// floor settings, random idling on both channels and overflowing columns.
// ----------------------------------------------------------------------------
module tb_top;

  // Fixed-point softmax predictor plus a queue of expected probabilities.
  class softmax_scoreboard;
    logic signed [15:0]     col_scores [16];
    int unsigned            col_count;
    logic signed [15:0]     col_max;
    bit                     col_overflow;
    logic [16:0]            floor_reg;
    csm_tb_pkg::prob_rec_t  pending_probs [$];
    int unsigned            errors;
    int unsigned            checked;

    function new();
      clear_column();
      floor_reg = 17'd1;
      errors = 0;
      checked = 0;
    endfunction

    function void clear_column();
      col_count = 0;
      col_max = -16'sd32768;
      col_overflow = 0;
    endfunction

    // exp(-x) for x in Q5.10, result Q1.16
    function longint unsigned exp_q16(longint unsigned x);
      longint unsigned u, k, h, l, a, p, m;
      u = (x * 94548 + 512) >> 10;
      k = u >> 16;
      h = (u >> 12) & 15;
      l = u & 12'hFFF;
      a = (l * 45426 + 32768) >> 16;
      p = 65536 - a + ((a * a + 65536) >> 17);
      m = (longint'(csm_pkg::pow2_frac(h[3:0])) * p + 32768) >> 16;
      if (k > 16) return 0;
      if (k == 0) return m;
      return (m + (longint'(1) << (k - 1))) >> k;
    endfunction

    // Note one accepted score; on the column end, queue the probabilities.
    function void note_score(logic signed [15:0] s, bit is_last);
      longint unsigned e [16];
      longint unsigned sum, pr, fl;
      csm_tb_pkg::prob_rec_t r;
      sum = 0;
      if (col_count < 16) begin
        col_scores[col_count] = s;
        if (s > col_max) col_max = s;
        col_count++;
      end else begin
        col_overflow = 1;
      end
      if (!is_last) return;
      for (int i = 0; i < col_count; i++) begin
        e[i] = exp_q16(longint'(int'(col_max) - int'(col_scores[i])));
        sum += e[i];
      end
      fl = (floor_reg > 65536) ? 65536 : floor_reg;
      for (int i = 0; i < col_count; i++) begin
        pr = ((e[i] << 16) + (sum >> 1)) / sum;
        if (pr < fl) pr = fl;
        r.probability = pr[16:0];
        r.row_index = i[3:0];
        r.last_of_column = (i + 1 == col_count);
        r.overflow = col_overflow;
        pending_probs.push_back(r);
      end
      clear_column();
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_prob(csm_tb_pkg::prob_rec_t got);
      csm_tb_pkg::prob_rec_t want;
      checked++;
      if (pending_probs.size() == 0) begin
        report($sformatf("unexpected probability %0d row %0d",
                         got.probability, got.row_index));
        return;
      end
      want = pending_probs.pop_front();
      if (got.probability !== want.probability)
        report($sformatf("row %0d probability %0d, want %0d", want.row_index,
                         got.probability, want.probability));
      if (got.row_index !== want.row_index)
        report($sformatf("row_index %0d, want %0d", got.row_index, want.row_index));
      if (got.last_of_column !== want.last_of_column)
        report($sformatf("row %0d last_of_column %0b, want %0b", want.row_index,
                         got.last_of_column, want.last_of_column));
      if (got.overflow !== want.overflow)
        report($sformatf("row %0d overflow %0b, want %0b", want.row_index,
                         got.overflow, want.overflow));
    endtask
  endclass

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [16:0] cfg_data = '0;
  bit          no_idle = 0;   // long stretch with both sides always busy
  int unsigned cycle = 0;
  int unsigned scores_sent = 0;
  int unsigned columns_sent = 0;

  csm_score_if in_ch ();
  csm_prob_if  out_ch ();

  softmax_scoreboard sb = new();

  column_softmax_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.score = '0;
    in_ch.last_in_column = 0;
    out_ch.ready = 0;
  end

  // Sink side: stall at random about 21 percent of the time, check each transaction.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_prob('{out_ch.probability, out_ch.row_index,
                        out_ch.last_of_column, out_ch.overflow});
      out_ch.ready <= no_idle || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one score and hold it until accepted, with random idle gaps.
  // Ready is sampled at the falling edge, where it is stable for the next
  // rising edge.
  task automatic send_score(logic signed [15:0] s, bit is_last);
    bit acc;
    while (!no_idle && $urandom_range(99) < 21) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.score <= s;
    in_ch.last_in_column <= is_last;
    do begin
      @(negedge clk);
      acc = in_ch.ready;
      @(posedge clk);
    end while (!acc);
    sb.note_score(s, is_last);
    scores_sent++;
    if (is_last) columns_sent++;
  endtask

  // Drop the input, wait for every queued probability, then settle.
  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending_probs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_floor(logic [16:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.floor_reg = v;
  endtask

  function automatic logic signed [15:0] rand_score(int unsigned spread);
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(spread) - spread / 2);
      2: return 16'(32'd32767 - $urandom_range(spread));
      default: return 16'(32'd32768 + $urandom_range(spread));
    endcase
  endfunction

  // Random column: mostly legal lengths, some overflowing past 16 rows.
  task automatic random_column(int unsigned spread);
    int unsigned len;
    len = ($urandom_range(9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
    for (int i = 0; i < len; i++)
      send_score(rand_score(spread), i == len - 1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: single row, extreme scores, equal scores, full and overflowing.
    send_score(16'sd0, 1);
    send_score(16'sd32767, 0);
    send_score(-16'sd32768, 1);
    send_score(16'sd1024, 0);
    send_score(16'sd1024, 0);
    send_score(16'sd1024, 1);
    for (int i = 0; i < 18; i++)
      send_score(i[0] ? -16'sd32768 : 16'sd32767, i == 17);

    write_floor(17'd0);
    for (int i = 0; i < 120; i++) begin
      no_idle = (scores_sent >= 60);
      if (scores_sent > 160) break;
      random_column($urandom_range(1, 16000));
    end
    no_idle = 0;
    write_floor(17'd65536);
    random_column(3000);
    random_column(300);
    write_floor(17'h1FFFF);   // above one: saturates to one
    random_column(65535);
    write_floor(17'($urandom_range(1, 4000)));
    while (scores_sent < 400) random_column($urandom_range(1, 65535));
    write_floor(17'd1);
    while (scores_sent < 460) random_column($urandom_range(1, 8000));
    drain();

    $display("covered %0d scores in %0d columns, %0d probabilities checked",
             scores_sent, columns_sent, sb.checked);
    $display("floors 0, 1, random, one and above one; columns of 1 to 22 rows");
    if (sb.errors == 0 && sb.pending_probs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
